FILE: rtl/ufs_pkg.sv
// ufs_pkg: shared constants for the union-find-by-size block.
// Used by ufs_ctrl, union_find_by_size and ufs_checker; no dependencies.
package ufs_pkg;

    localparam int N_ELEMENTS_DEF = 1024;
    localparam int ELEM_W         = 10;
    localparam int SIZE_W         = 11;
    localparam int OP_W           = 2;

    localparam logic [OP_W-1:0] OP_UNION = 2'd0;
    localparam logic [OP_W-1:0] OP_FIND  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [SIZE_W-1:0] SIZE_ONE = 11'd1;

endpackage

FILE: rtl/ufs_table.sv
// ufs_table: single-port-write, single-port-read synchronous memory holding
// {set size, parent link} per element. Read data is registered. No dependencies.
module ufs_table #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10,
    parameter int DATA_W = 21
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/ufs_ctrl.sv
// ufs_ctrl: sequencer for clear sweeps, index reduction, root walks and merges,
// plus the result register. Depends on ufs_pkg; drives the ufs_table ports.
module ufs_ctrl #(
    parameter int N_ELEMENTS = ufs_pkg::N_ELEMENTS_DEF,
    parameter int IW         = $clog2(N_ELEMENTS),
    parameter int DATA_W     = ufs_pkg::SIZE_W + IW
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [ufs_pkg::OP_W-1:0]    i_opcode,
    input  logic [ufs_pkg::ELEM_W-1:0]  i_elem_a,
    input  logic [ufs_pkg::ELEM_W-1:0]  i_elem_b,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [ufs_pkg::ELEM_W-1:0]  o_root_a,
    output logic [ufs_pkg::ELEM_W-1:0]  o_root_b,
    output logic                        o_same_set,
    output logic [ufs_pkg::ELEM_W-1:0]  o_merged_root,
    output logic                        o_wr_en,
    output logic [IW-1:0]               o_wr_addr,
    output logic [DATA_W-1:0]           o_wr_data,
    output logic                        o_rd_en,
    output logic [IW-1:0]               o_rd_addr,
    input  logic [DATA_W-1:0]           i_rd_data
);

    localparam int  EW        = ufs_pkg::ELEM_W;
    localparam int  SW        = ufs_pkg::SIZE_W;
    localparam int  EXT_W     = (IW > EW) ? IW : EW;
    localparam int  CNT_W     = $clog2(EW);
    localparam bit  NEEDS_MOD = (N_ELEMENTS < (1 << EW)) &&
                                ((N_ELEMENTS & (N_ELEMENTS - 1)) != 0);
    localparam logic [IW-1:0]    LAST_IDX = IW'(N_ELEMENTS - 1);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(EW - 1);
    localparam logic [IW:0]      N_EXT    = (IW + 1)'(N_ELEMENTS);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_REDUCE,
        S_WALK_A,
        S_WALK_B,
        S_WR_LOSER,
        S_WR_WINNER,
        S_DONE
    } t_state;

    t_state          r_state, n_state;
    logic [IW-1:0]   r_clr_addr, n_clr_addr;
    logic            r_clr_item, n_clr_item;
    logic            r_out_valid, n_out_valid;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    logic [ufs_pkg::OP_W-1:0] r_op, n_op;
    logic [EW-1:0]   r_sh_a, n_sh_a, r_sh_b, n_sh_b;
    logic [IW-1:0]   r_rem_a, n_rem_a, r_rem_b, n_rem_b;
    logic [IW-1:0]   r_cur, n_cur;
    logic [IW-1:0]   r_b, n_b;
    logic [IW-1:0]   r_ra, n_ra, r_rb, n_rb, r_merged, n_merged;
    logic [SW-1:0]   r_size_a, n_size_a, r_size_b, n_size_b;
    logic            r_same, n_same;
    logic [EW-1:0]   r_o_ra, n_o_ra, r_o_rb, n_o_rb, r_o_mg, n_o_mg;
    logic            r_o_same, n_o_same;

    function automatic logic [IW-1:0] red_step(input logic [IW-1:0] rem, input logic bit_in);
        logic [IW:0] t;
        t = {rem, bit_in};
        if (t >= N_EXT) begin
            t = t - N_EXT;
        end
        return t[IW-1:0];
    endfunction

    function automatic logic [IW-1:0] to_idx(input logic [EW-1:0] v);
        logic [EXT_W-1:0] t;
        t = EXT_W'(v);
        return t[IW-1:0];
    endfunction

    function automatic logic [EW-1:0] to_out(input logic [IW-1:0] v);
        logic [EXT_W-1:0] t;
        t = EXT_W'(v);
        return t[EW-1:0];
    endfunction

    always_comb begin
        logic [IW-1:0] parent;
        logic [SW-1:0] size_rd;
        logic          a_wins;
        logic [IW-1:0] winner, loser;
        logic [SW-1:0] loser_size;

        parent     = i_rd_data[IW-1:0];
        size_rd    = i_rd_data[DATA_W-1 -: SW];
        a_wins     = r_size_a > r_size_b;
        winner     = a_wins ? r_ra : r_rb;
        loser      = a_wins ? r_rb : r_ra;
        loser_size = a_wins ? r_size_b : r_size_a;

        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_clr_item  = r_clr_item;
        n_out_valid = r_out_valid && i_out_stall;
        n_cnt       = r_cnt;
        n_op        = r_op;
        n_sh_a      = r_sh_a;
        n_sh_b      = r_sh_b;
        n_rem_a     = r_rem_a;
        n_rem_b     = r_rem_b;
        n_cur       = r_cur;
        n_b         = r_b;
        n_ra        = r_ra;
        n_rb        = r_rb;
        n_merged    = r_merged;
        n_size_a    = r_size_a;
        n_size_b    = r_size_b;
        n_same      = r_same;
        n_o_ra      = r_o_ra;
        n_o_rb      = r_o_rb;
        n_o_mg      = r_o_mg;
        n_o_same    = r_o_same;

        o_wr_en   = 1'b0;
        o_wr_addr = r_clr_addr;
        o_wr_data = {ufs_pkg::SIZE_ONE, r_clr_addr};
        o_rd_en   = 1'b0;
        o_rd_addr = r_cur;

        case (r_state)
            S_CLEAR: begin
                o_wr_en    = 1'b1;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == LAST_IDX) begin
                    n_clr_addr = '0;
                    n_state    = r_clr_item ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op = i_opcode;
                    if (i_opcode == ufs_pkg::OP_CLEAR) begin
                        n_clr_item = 1'b1;
                        n_ra       = '0;
                        n_rb       = '0;
                        n_merged   = '0;
                        n_same     = 1'b0;
                        n_state    = S_CLEAR;
                    end else if (NEEDS_MOD) begin
                        n_sh_a  = i_elem_a;
                        n_sh_b  = i_elem_b;
                        n_rem_a = '0;
                        n_rem_b = '0;
                        n_cnt   = '0;
                        n_state = S_REDUCE;
                    end else begin
                        o_rd_en   = 1'b1;
                        o_rd_addr = to_idx(i_elem_a);
                        n_cur     = to_idx(i_elem_a);
                        n_b       = to_idx(i_elem_b);
                        n_state   = S_WALK_A;
                    end
                end
            end
            S_REDUCE: begin
                n_rem_a = red_step(r_rem_a, r_sh_a[EW-1]);
                n_rem_b = red_step(r_rem_b, r_sh_b[EW-1]);
                n_sh_a  = {r_sh_a[EW-2:0], 1'b0};
                n_sh_b  = {r_sh_b[EW-2:0], 1'b0};
                n_cnt   = r_cnt + 1'b1;
                if (r_cnt == LAST_CNT) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = n_rem_a;
                    n_cur     = n_rem_a;
                    n_b       = n_rem_b;
                    n_state   = S_WALK_A;
                end
            end
            S_WALK_A: begin
                o_rd_en = 1'b1;
                if (parent == r_cur) begin
                    n_ra      = r_cur;
                    n_size_a  = size_rd;
                    o_rd_addr = r_b;
                    n_cur     = r_b;
                    n_state   = S_WALK_B;
                end else begin
                    o_rd_addr = parent;
                    n_cur     = parent;
                end
            end
            S_WALK_B: begin
                if (parent == r_cur) begin
                    n_rb     = r_cur;
                    n_size_b = size_rd;
                    n_same   = (r_ra == r_cur);
                    n_merged = r_cur;
                    if (r_op == ufs_pkg::OP_UNION && r_ra != r_cur) begin
                        n_state = S_WR_LOSER;
                    end else begin
                        n_state = S_DONE;
                    end
                end else begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = parent;
                    n_cur     = parent;
                end
            end
            S_WR_LOSER: begin
                o_wr_en   = 1'b1;
                o_wr_addr = loser;
                o_wr_data = {loser_size, winner};
                n_merged  = winner;
                n_state   = S_WR_WINNER;
            end
            S_WR_WINNER: begin
                o_wr_en   = 1'b1;
                o_wr_addr = winner;
                o_wr_data = {SW'(r_size_a + r_size_b), winner};
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_o_ra      = to_out(r_ra);
                    n_o_rb      = to_out(r_rb);
                    n_o_mg      = to_out(r_merged);
                    n_o_same    = r_same;
                    n_clr_item  = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_clr_item  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_clr_item  <= n_clr_item;
            r_out_valid <= n_out_valid;
            r_cnt       <= n_cnt;
        end
        r_op     <= n_op;
        r_sh_a   <= n_sh_a;
        r_sh_b   <= n_sh_b;
        r_rem_a  <= n_rem_a;
        r_rem_b  <= n_rem_b;
        r_cur    <= n_cur;
        r_b      <= n_b;
        r_ra     <= n_ra;
        r_rb     <= n_rb;
        r_merged <= n_merged;
        r_size_a <= n_size_a;
        r_size_b <= n_size_b;
        r_same   <= n_same;
        r_o_ra   <= n_o_ra;
        r_o_rb   <= n_o_rb;
        r_o_mg   <= n_o_mg;
        r_o_same <= n_o_same;
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_root_a      = r_o_ra;
    assign o_root_b      = r_o_rb;
    assign o_same_set    = r_o_same;
    assign o_merged_root = r_o_mg;

endmodule

FILE: rtl/union_find_by_size.sv
// union_find_by_size: top level of the disjoint-set forest with union by size.
// Depends on ufs_pkg, ufs_table and ufs_ctrl.
//
// Input channel: i_in_valid / o_in_stall with i_opcode, i_elem_a, i_elem_b.
// Output channel: o_out_valid / i_out_stall with o_root_a, o_root_b,
// o_same_set, o_merged_root. A transaction completes on a rising edge with
// valid high and stall low. Every input transaction yields one result.
// One transaction is in work at a time; o_in_stall is high until it is done.
// A find or union walks La then Lb parent links before o_out_valid, where La
// and Lb are at most log2(N_ELEMENTS) each, one link per cycle through the
// table read port; a merging union then makes its two table writes, and when
// N_ELEMENTS is not a power of two and below 1024 an index reduction step runs
// first. A clear writes all N_ELEMENTS table entries, one entry per cycle.
// Reset starts the same clearing pass, with o_in_stall high.
// A stalled result holds in the output register; the next transaction is
// accepted meanwhile and waits for that register before its result shows.
module union_find_by_size #(
    parameter int N_ELEMENTS = ufs_pkg::N_ELEMENTS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [ufs_pkg::OP_W-1:0]    i_opcode,
    input  logic [ufs_pkg::ELEM_W-1:0]  i_elem_a,
    input  logic [ufs_pkg::ELEM_W-1:0]  i_elem_b,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [ufs_pkg::ELEM_W-1:0]  o_root_a,
    output logic [ufs_pkg::ELEM_W-1:0]  o_root_b,
    output logic                        o_same_set,
    output logic [ufs_pkg::ELEM_W-1:0]  o_merged_root
);

    localparam int IW     = $clog2(N_ELEMENTS);
    localparam int DATA_W = ufs_pkg::SIZE_W + IW;

    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [IW-1:0]     rd_addr;
    logic [DATA_W-1:0] rd_data;

    ufs_table #(
        .DEPTH  (N_ELEMENTS),
        .ADDR_W (IW),
        .DATA_W (DATA_W)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    ufs_ctrl #(
        .N_ELEMENTS (N_ELEMENTS),
        .IW         (IW),
        .DATA_W     (DATA_W)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_elem_a      (i_elem_a),
        .i_elem_b      (i_elem_b),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_root_a      (o_root_a),
        .o_root_b      (o_root_b),
        .o_same_set    (o_same_set),
        .o_merged_root (o_merged_root),
        .o_wr_en       (wr_en),
        .o_wr_addr     (wr_addr),
        .o_wr_data     (wr_data),
        .o_rd_en       (rd_en),
        .o_rd_addr     (rd_addr),
        .i_rd_data     (rd_data)
    );

endmodule

FILE: rtl/ufs_checker.sv
// ufs_checker: port-level assertions for union_find_by_size, bound to the top.
// Depends on ufs_pkg.
module ufs_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        o_in_stall,
    input  logic                        o_out_valid,
    input  logic                        i_out_stall,
    input  logic [ufs_pkg::ELEM_W-1:0]  o_root_a,
    input  logic [ufs_pkg::ELEM_W-1:0]  o_root_b,
    input  logic                        o_same_set,
    input  logic [ufs_pkg::ELEM_W-1:0]  o_merged_root
);

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_root_a) &&
        $stable(o_root_b) && $stable(o_same_set) && $stable(o_merged_root))
        else $error("stalled result changed");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input not stalled during clearing pass");

    a_one_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second transaction taken while busy");

    a_same_roots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_same_set |->
        o_root_a == o_root_b && o_merged_root == o_root_b)
        else $error("same_set with differing roots");

    a_merged_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_merged_root == o_root_a || o_merged_root == o_root_b)
        else $error("merged root is neither root");

endmodule

bind union_find_by_size ufs_checker u_ufs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_root_a      (o_root_a),
    .o_root_b      (o_root_b),
    .o_same_set    (o_same_set),
    .o_merged_root (o_merged_root)
);

FILE: tb/union_find_by_size_tb.sv
// union_find_by_size_tb: self-checking testbench for union_find_by_size.
// Runs a directed table and then random unions, finds and clears; checks typed
// steps against literals, others against a software forest model. Depends on ufs_pkg.
module union_find_by_size_tb;

    localparam int N            = ufs_pkg::N_ELEMENTS_DEF;
    localparam int OP_W         = ufs_pkg::OP_W;
    localparam int ELEM_W       = ufs_pkg::ELEM_W;
    localparam int SIZE_W       = ufs_pkg::SIZE_W;
    localparam int N_DIRECTED   = 21;
    localparam int RANDOM_ITEMS = 530;
    localparam int PHASE_ITEMS  = 66;
    localparam int WINDOW_W     = 48;
    localparam int QUIET_LIMIT  = 20000;
    localparam int TAIL_CYCLES  = 40;

    localparam logic [OP_W-1:0]   OP_UNION = ufs_pkg::OP_UNION;
    localparam logic [OP_W-1:0]   OP_FIND  = ufs_pkg::OP_FIND;
    localparam logic [OP_W-1:0]   OP_CLEAR = ufs_pkg::OP_CLEAR;
    localparam logic [OP_W-1:0]   OP_SPARE = 2'd3;
    localparam logic [SIZE_W-1:0] SIZE_ONE = ufs_pkg::SIZE_ONE;

    typedef struct packed {
        logic [ELEM_W-1:0] root_a;
        logic [ELEM_W-1:0] root_b;
        logic              same_set;
        logic [ELEM_W-1:0] merged_root;
    } t_roots;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ELEM_W-1:0] a;
        logic [ELEM_W-1:0] b;
        logic              typed;
        logic [ELEM_W-1:0] ra;
        logic [ELEM_W-1:0] rb;
        logic              same;
        logic [ELEM_W-1:0] merged;
    } t_step;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    logic [OP_W-1:0]   i_opcode;
    logic [ELEM_W-1:0] i_elem_a;
    logic [ELEM_W-1:0] i_elem_b;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [ELEM_W-1:0] o_root_a;
    logic [ELEM_W-1:0] o_root_b;
    logic              o_same_set;
    logic [ELEM_W-1:0] o_merged_root;

    union_find_by_size DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_elem_a      (i_elem_a),
        .i_elem_b      (i_elem_b),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_root_a      (o_root_a),
        .o_root_b      (o_root_b),
        .o_same_set    (o_same_set),
        .o_merged_root (o_merged_root)
    );

    logic [ELEM_W-1:0] forest_parent [N];
    logic [SIZE_W-1:0] forest_size   [N];
    t_roots            pending_roots [$];
    t_step             directed_steps [N_DIRECTED];

    int fail_count     = 0;
    int quiet_cycles   = 0;
    int item_count     = 0;
    int send_idle_pct  = 0;
    int stall_pct      = 0;

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    function automatic void reset_forest();
        for (int i = 0; i < N; i++) begin
            forest_parent[i] = ELEM_W'(i);
            forest_size[i]   = SIZE_ONE;
        end
    endfunction

    function automatic logic [ELEM_W-1:0] root_of(input logic [ELEM_W-1:0] e);
        for (int s = 0; s < N; s++) begin
            if (forest_parent[e] == e) break;
            e = forest_parent[e];
        end
        return e;
    endfunction

    function automatic t_roots predict_roots(input logic [OP_W-1:0] op,
                                             input logic [ELEM_W-1:0] a,
                                             input logic [ELEM_W-1:0] b);
        t_roots res;
        if (op == OP_CLEAR) begin
            reset_forest();
            return '0;
        end
        res.root_a      = root_of(a);
        res.root_b      = root_of(b);
        res.same_set    = (res.root_a == res.root_b);
        res.merged_root = res.root_b;
        if (op == OP_UNION && !res.same_set) begin
            if (forest_size[res.root_a] > forest_size[res.root_b]) begin
                forest_parent[res.root_b] = res.root_a;
                forest_size[res.root_a]   = forest_size[res.root_a] + forest_size[res.root_b];
                res.merged_root           = res.root_a;
            end else begin
                forest_parent[res.root_a] = res.root_b;
                forest_size[res.root_b]   = forest_size[res.root_b] + forest_size[res.root_a];
            end
        end
        return res;
    endfunction

    task automatic send_item(input logic [OP_W-1:0] op, input logic [ELEM_W-1:0] a,
                             input logic [ELEM_W-1:0] b, input logic typed,
                             input t_roots literal);
        t_roots predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_elem_a   <= a;
        i_elem_b   <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predicted = predict_roots(op, a, b);
        pending_roots.push_back(typed ? literal : predicted);
        item_count++;
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_roots.size() != 0) @(posedge i_clk);
    endtask

    // equal-size pairings give the deepest trees union by size allows
    task automatic build_deep(input logic [ELEM_W-1:0] base, input int depth);
        for (int s = 1; s < (1 << depth); s = s * 2) begin
            for (int i = 0; i < (1 << depth); i = i + 2 * s) begin
                send_item(OP_UNION, base + ELEM_W'(i), base + ELEM_W'(i + s), 1'b0, '0);
            end
        end
        send_item(OP_FIND, base, base + ELEM_W'((1 << depth) - 1), 1'b0, '0);
    endtask

    always @(posedge i_clk) begin
        t_roots want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_roots.size() == 0) begin
                    $error("unexpected transaction: root_a %0d root_b %0d", o_root_a, o_root_b);
                    fail_count++;
                end else begin
                    want = pending_roots.pop_front();
                    if (o_root_a !== want.root_a) begin
                        $error("root_a: expected %0d, got %0d", want.root_a, o_root_a);
                        fail_count++;
                    end
                    if (o_root_b !== want.root_b) begin
                        $error("root_b: expected %0d, got %0d", want.root_b, o_root_b);
                        fail_count++;
                    end
                    if (o_same_set !== want.same_set) begin
                        $error("same_set: expected %0d, got %0d", want.same_set, o_same_set);
                        fail_count++;
                    end
                    if (o_merged_root !== want.merged_root) begin
                        $error("merged_root: expected %0d, got %0d",
                               want.merged_root, o_merged_root);
                        fail_count++;
                    end
                end
            end
        end
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
            $display("FAIL union_find_by_size");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    initial begin
        int                r;
        int                mode;
        int                phase_end;
        logic [ELEM_W-1:0] window_base;
        logic [OP_W-1:0]   op;
        t_step             st;

        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_opcode    <= OP_FIND;
        i_elem_a    <= '0;
        i_elem_b    <= '0;
        i_out_stall <= 1'b0;
        reset_forest();

        directed_steps = '{
            '{OP_FIND,  10'd0,    10'd1023, 1'b1, 10'd0,    10'd1023, 1'b0, 10'd1023},
            '{OP_UNION, 10'd0,    10'd1023, 1'b1, 10'd0,    10'd1023, 1'b0, 10'd1023},
            '{OP_FIND,  10'd0,    10'd1023, 1'b1, 10'd1023, 10'd1023, 1'b1, 10'd1023},
            '{OP_UNION, 10'd1023, 10'd0,    1'b1, 10'd1023, 10'd1023, 1'b1, 10'd1023},
            '{OP_UNION, 10'd5,    10'd5,    1'b1, 10'd5,    10'd5,    1'b1, 10'd5},
            '{OP_SPARE, 10'd0,    10'd5,    1'b1, 10'd1023, 10'd5,    1'b0, 10'd5},
            '{OP_UNION, 10'd5,    10'd0,    1'b1, 10'd5,    10'd1023, 1'b0, 10'd1023},
            '{OP_CLEAR, 10'd7,    10'd9,    1'b1, 10'd0,    10'd0,    1'b0, 10'd0},
            '{OP_FIND,  10'd1023, 10'd0,    1'b1, 10'd1023, 10'd0,    1'b0, 10'd0},
            '{OP_UNION, 10'd1,    10'd2,    1'b1, 10'd1,    10'd2,    1'b0, 10'd2},
            '{OP_UNION, 10'd2,    10'd3,    1'b1, 10'd2,    10'd3,    1'b0, 10'd2},
            '{OP_UNION, 10'd4,    10'd3,    1'b1, 10'd4,    10'd2,    1'b0, 10'd2},
            '{OP_UNION, 10'd8,    10'd9,    1'b0, 10'd0,    10'd0,    1'b0, 10'd0},
            '{OP_UNION, 10'd10,   10'd11,   1'b0, 10'd0,    10'd0,    1'b0, 10'd0},
            '{OP_UNION, 10'd8,    10'd10,   1'b0, 10'd0,    10'd0,    1'b0, 10'd0},
            '{OP_UNION, 10'd1,    10'd8,    1'b0, 10'd0,    10'd0,    1'b0, 10'd0},
            '{OP_FIND,  10'd3,    10'd9,    1'b0, 10'd0,    10'd0,    1'b0, 10'd0},
            '{OP_UNION, 10'd682,  10'd341,  1'b0, 10'd0,    10'd0,    1'b0, 10'd0},
            '{OP_SPARE, 10'd1023, 10'd1023, 1'b0, 10'd0,    10'd0,    1'b0, 10'd0},
            '{OP_UNION, 10'd512,  10'd511,  1'b0, 10'd0,    10'd0,    1'b0, 10'd0},
            '{OP_CLEAR, 10'd1023, 10'd1023, 1'b1, 10'd0,    10'd0,    1'b0, 10'd0}
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 22;
        stall_pct     = 22;
        for (int k = 0; k < N_DIRECTED; k++) begin
            st = directed_steps[k];
            send_item(st.op, st.a, st.b, st.typed,
                      t_roots'{st.ra, st.rb, st.same, st.merged});
        end
        wait_drained();

        window_base = ELEM_W'($urandom_range(N - 1));
        for (int phase = 0; item_count < N_DIRECTED + RANDOM_ITEMS; phase++) begin
            mode = phase % 4;
            case (mode)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 80; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 80; end
                default: begin send_idle_pct = 22; stall_pct = 22; end
            endcase
            phase_end = item_count + PHASE_ITEMS;
            while (item_count < phase_end && item_count < N_DIRECTED + RANDOM_ITEMS) begin
                if ($urandom_range(19) == 0) window_base = ELEM_W'($urandom_range(N - 1));
                r = $urandom_range(99);
                if (r < 3) begin
                    build_deep(ELEM_W'($urandom_range(N - 1)), $urandom_range(5, 2));
                end else if (r < 5) begin
                    send_item(OP_CLEAR, ELEM_W'($urandom), ELEM_W'($urandom), 1'b0, '0);
                end else if (r < 8) begin
                    send_item(OP_SPARE, ELEM_W'($urandom), ELEM_W'($urandom), 1'b0, '0);
                end else if (r < 80) begin
                    op = (r < 60) ? OP_UNION : OP_FIND;
                    send_item(op, window_base + ELEM_W'($urandom_range(WINDOW_W - 1)),
                              window_base + ELEM_W'($urandom_range(WINDOW_W - 1)), 1'b0, '0);
                end else begin
                    op = $urandom_range(1) ? OP_UNION : OP_FIND;
                    send_item(op, ELEM_W'($urandom), ELEM_W'($urandom), 1'b0, '0);
                end
            end
            wait_drained();
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASS union_find_by_size");
        end else begin
            $display("FAIL union_find_by_size");
        end
        $finish;
    end

endmodule
